/* hdl/trlc_pkg.sv */
// ----------------------------------------------------------------------------
// trlc_pkg
// Shared types, constants and letter arithmetic for the three-rotor cipher.
// ----------------------------------------------------------------------------
package trlc_pkg;

    typedef logic [4:0] letter_t;

    typedef struct packed {
        letter_t fast;
        letter_t mid;
        letter_t slow;
    } rotor_pos_t;

    typedef enum logic [1:0] {
        REG_START_FAST = 2'd0,
        REG_START_MID  = 2'd1,
        REG_START_SLOW = 2'd2
    } cfg_reg_t;

    localparam letter_t LETTER_LAST = 5'd25;
    localparam letter_t RESET_FAST  = 5'd8;
    localparam letter_t RESET_MID   = 5'd19;
    localparam letter_t RESET_SLOW  = 5'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // Pairwise swap A<->B, C<->D, ... used by plugboard, rotors and reflector
    localparam letter_t SWAP_TABLE [26] = '{
        5'd1,  5'd0,  5'd3,  5'd2,  5'd5,  5'd4,  5'd7,  5'd6,  5'd9,
        5'd8,  5'd11, 5'd10, 5'd13, 5'd12, 5'd15, 5'd14, 5'd17, 5'd16,
        5'd19, 5'd18, 5'd21, 5'd20, 5'd23, 5'd22, 5'd25, 5'd24
    };

    function automatic letter_t swap_letter(input letter_t v);
        letter_t r;
        if (v <= LETTER_LAST)
            r = SWAP_TABLE[v];
        else
            r = '0;
        return r;
    endfunction

    // (a + b) mod 26 for a, b below 26
    function automatic letter_t add_mod(input letter_t a, input letter_t b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, LETTER_LAST})
            s = s - 6'd26;
        return s[4:0];
    endfunction

    // (a - b) mod 26 for a, b below 26
    function automatic letter_t sub_mod(input letter_t a, input letter_t b);
        logic [5:0] d;
        d = {1'b0, a} + 6'd26 - {1'b0, b};
        if (d > {1'b0, LETTER_LAST})
            d = d - 6'd26;
        return d[4:0];
    endfunction

    // Fold a raw 5-bit register value into 0..25
    function automatic letter_t reduce_letter(input letter_t v);
        letter_t r;
        if (v > LETTER_LAST)
            r = v - 5'd26;
        else
            r = v;
        return r;
    endfunction

    function automatic letter_t inc_mod(input letter_t v);
        letter_t r;
        if (v >= LETTER_LAST)
            r = '0;
        else
            r = v + 5'd1;
        return r;
    endfunction

endpackage

/* hdl/three_rotor_letter_cipher_core.sv */
// ----------------------------------------------------------------------------
// three_rotor_letter_cipher_core
// Three-rotor letter cipher on a byte stream, one character per clock while m_tready is high.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  -------  ---  -----------------  ----------------------------------------
//  s_axis   in   s_tvalid/s_tready  tdata: in_char; tuser: new_message
//  m_axis   out  m_tvalid/m_tready  tdata: out_char, used fast/mid/slow pos;
//                                   tuser: was_letter
//  cfg      in   cfg_we             cfg_index selects start position register
//
//  Each transaction is captured in the input register, then enciphered
//  and stepped in a single pass into the result register; one transaction
//  per cycle is sustained while m_tready is high, as each character must
//  see the rotor position update from the one before it.
//  Reset loads the start registers and the rotor positions with 8, 19 and 2.
//  A stall on m_tready holds the result register and the input register;
//  s_tready drops only when both are full and the result is not taken.
// ----------------------------------------------------------------------------
module three_rotor_letter_cipher_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_char
    input  logic        s_tuser,    // [0] new_message

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] out_char, [12:8] used_fast_pos,
                                    // [17:13] used_mid_pos, [22:18] used_slow_pos,
                                    // [23] zero
    output logic        m_tuser,    // [0] was_letter

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    // Input register
    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [7:0]           in_char_reg;
    logic                 in_newmsg_reg;

    // Result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_char_reg;
    logic                 out_letter_reg;
    trlc_pkg::rotor_pos_t out_pos_reg;

    logic                 s_accept;
    logic                 advance;
    logic                 is_letter;
    logic [7:0]           enc_char;
    trlc_pkg::rotor_pos_t cur_pos;

    // Move the held character into the result register when that slot frees
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    trlc_rotor_pos u_rotor_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .advance     (advance),
        .new_message (in_newmsg_reg),
        .is_letter   (is_letter),
        .cur_pos     (cur_pos)
    );

    trlc_path u_path (
        .in_char   (in_char_reg),
        .pos       (cur_pos),
        .out_char  (enc_char),
        .is_letter (is_letter)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_char_reg   <= s_tdata;
            in_newmsg_reg <= s_tuser;
        end
        if (advance)
        begin
            out_char_reg   <= enc_char;
            out_letter_reg <= is_letter;
            out_pos_reg    <= cur_pos;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pos_reg.slow, out_pos_reg.mid, out_pos_reg.fast, out_char_reg};
    assign m_tuser  = out_letter_reg;

endmodule

/* hdl/trlc_rotor_pos.sv */
// ----------------------------------------------------------------------------
// trlc_rotor_pos
// Start position registers, live rotor positions and odometer stepping.
// ----------------------------------------------------------------------------
module trlc_rotor_pos (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [4:0]            cfg_data,
    input  logic                  advance,      // an item is being processed
    input  logic                  new_message,
    input  logic                  is_letter,
    output trlc_pkg::rotor_pos_t  cur_pos       // positions used for this item
);

    trlc_pkg::rotor_pos_t start_reg;
    trlc_pkg::rotor_pos_t start_next;
    trlc_pkg::rotor_pos_t pos_reg;
    trlc_pkg::rotor_pos_t pos_next;
    trlc_pkg::rotor_pos_t stepped;

    always_comb
    begin
        start_next = start_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                trlc_pkg::REG_START_FAST: start_next.fast = cfg_data;
                trlc_pkg::REG_START_MID:  start_next.mid  = cfg_data;
                trlc_pkg::REG_START_SLOW: start_next.slow = cfg_data;
                default:                  start_next      = start_reg;
            endcase
        end
    end

    // Reload ahead of this item when it opens a new message
    always_comb
    begin
        if (new_message)
        begin
            cur_pos.fast = trlc_pkg::reduce_letter(start_reg.fast);
            cur_pos.mid  = trlc_pkg::reduce_letter(start_reg.mid);
            cur_pos.slow = trlc_pkg::reduce_letter(start_reg.slow);
        end
        else
        begin
            cur_pos = pos_reg;
        end
    end

    // Odometer: fast always, middle on fast wrap, slow on middle wrap
    always_comb
    begin
        stepped      = cur_pos;
        stepped.fast = trlc_pkg::inc_mod(cur_pos.fast);
        if (cur_pos.fast == trlc_pkg::LETTER_LAST)
        begin
            stepped.mid = trlc_pkg::inc_mod(cur_pos.mid);
            if (cur_pos.mid == trlc_pkg::LETTER_LAST)
                stepped.slow = trlc_pkg::inc_mod(cur_pos.slow);
        end
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (advance)
            pos_next = is_letter ? stepped : cur_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg.fast <= trlc_pkg::RESET_FAST;
            start_reg.mid  <= trlc_pkg::RESET_MID;
            start_reg.slow <= trlc_pkg::RESET_SLOW;
            pos_reg.fast   <= trlc_pkg::RESET_FAST;
            pos_reg.mid    <= trlc_pkg::RESET_MID;
            pos_reg.slow   <= trlc_pkg::RESET_SLOW;
        end
        else
        begin
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

/* hdl/trlc_path.sv */
// ----------------------------------------------------------------------------
// trlc_path
// Letter path: plugboard, three rotors, reflector, back through the rotors and plugboard.
// ----------------------------------------------------------------------------
module trlc_path (
    input  logic [7:0]            in_char,
    input  trlc_pkg::rotor_pos_t  pos,
    output logic [7:0]            out_char,
    output logic                  is_letter
);

    logic              upper;
    logic              lower;
    logic [7:0]        offset;
    trlc_pkg::letter_t idx;
    trlc_pkg::letter_t plug_in;
    trlc_pkg::letter_t f_fast;
    trlc_pkg::letter_t f_mid;
    trlc_pkg::letter_t f_slow;
    trlc_pkg::letter_t refl;
    trlc_pkg::letter_t b_slow;
    trlc_pkg::letter_t b_mid;
    trlc_pkg::letter_t b_fast;
    trlc_pkg::letter_t plug_out;

    assign upper = (in_char >= trlc_pkg::CHAR_UPPER_A) && (in_char <= trlc_pkg::CHAR_UPPER_Z);
    assign lower = (in_char >= trlc_pkg::CHAR_LOWER_A) && (in_char <= trlc_pkg::CHAR_LOWER_Z);
    assign is_letter = upper || lower;

    // Fold case: distance from 'A' or 'a'
    assign offset = upper ? (in_char - trlc_pkg::CHAR_UPPER_A)
                          : (in_char - trlc_pkg::CHAR_LOWER_A);
    assign idx    = offset[4:0];

    always_comb
    begin
        plug_in  = trlc_pkg::swap_letter(idx);
        f_fast   = trlc_pkg::add_mod(trlc_pkg::swap_letter(plug_in), pos.fast);
        f_mid    = trlc_pkg::add_mod(trlc_pkg::swap_letter(f_fast), pos.mid);
        f_slow   = trlc_pkg::add_mod(trlc_pkg::swap_letter(f_mid), pos.slow);
        refl     = trlc_pkg::swap_letter(f_slow);
        b_slow   = trlc_pkg::swap_letter(trlc_pkg::sub_mod(refl, pos.slow));
        b_mid    = trlc_pkg::swap_letter(trlc_pkg::sub_mod(b_slow, pos.mid));
        b_fast   = trlc_pkg::swap_letter(trlc_pkg::sub_mod(b_mid, pos.fast));
        plug_out = trlc_pkg::swap_letter(b_fast);
    end

    // Non-letters pass unchanged
    assign out_char = is_letter ? ({3'b000, plug_out} + trlc_pkg::CHAR_UPPER_A) : in_char;

endmodule
